/* sv/strmm_pkg.sv */
// ----------------------------------------------------------------------------
// strmm_pkg
// shared widths, codes, microcode format and control store of the range
// min/max tree core
// ----------------------------------------------------------------------------
package strmm_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register word index taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    localparam logic [VAL_W-1:0] ACC_ID_MIN = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] ACC_ID_MAX = {VAL_W{1'b0}};

    // microprogram step addresses
    typedef enum logic [4:0] {
        UP_IDLE,
        UP_R_INIT,
        UP_R_LEAF,
        UP_R_TOP,
        UP_R_RD,
        UP_R_WR,
        UP_U_LD,
        UP_U_RD,
        UP_U_CHK,
        UP_U_WR,
        UP_U_KRD,
        UP_U_KWR,
        UP_Q_LD,
        UP_Q_RD,
        UP_Q_ACC,
        UP_Q_OUT,
        UP_Q_ERR
    } t_upc;

    typedef enum logic [1:0] {RD_NONE, RD_P, RD_KIDS, RD_LR} t_rd;
    typedef enum logic [1:0] {WR_NONE, WR_LEAF, WR_VAL, WR_KIDS} t_wr;
    typedef enum logic [2:0] {P_HOLD, P_CLR, P_INC, P_DEC, P_HALF, P_LOAD, P_TOP} t_pop;
    typedef enum logic [1:0] {LR_HOLD, LR_LOAD, LR_STEP} t_lrop;
    typedef enum logic [1:0] {ACC_HOLD, ACC_INIT, ACC_FOLD} t_accop;
    typedef enum logic [1:0] {OUT_NONE, OUT_ACC, OUT_ERR} t_outop;
    typedef enum logic [2:0] {
        C_ALWAYS, C_LEAF_LAST, C_P_ONE, C_UPD_BAD, C_QRY_BAD, C_SAME, C_LR_DONE
    } t_cond;

    typedef struct packed {
        t_rd    rd;
        t_wr    wr;
        t_pop   pop;
        t_lrop  lrop;
        t_accop accop;
        t_outop outop;
        logic   dispatch;
        t_cond  cond;
        t_upc   tgt_t;
        t_upc   tgt_f;
    } t_uword;

    function automatic logic [VAL_W-1:0] f_comb(input logic mode,
                                                input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        if (mode == MODE_MAX) begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    // control store
    function automatic t_uword f_ucode(input t_upc pc);
        t_uword w;
        w       = '0;
        w.tgt_t = UP_IDLE;
        w.tgt_f = UP_IDLE;
        unique case (pc)
            UP_IDLE: begin
                w.dispatch = 1'b1;
            end
            // rebuild: leaves first, then inner nodes from the top leaf parent down
            UP_R_INIT: begin
                w.pop   = P_CLR;
                w.tgt_t = UP_R_LEAF;
            end
            UP_R_LEAF: begin
                w.wr    = WR_LEAF;
                w.pop   = P_INC;
                w.cond  = C_LEAF_LAST;
                w.tgt_t = UP_R_TOP;
                w.tgt_f = UP_R_LEAF;
            end
            UP_R_TOP: begin
                w.pop   = P_TOP;
                w.tgt_t = UP_R_RD;
            end
            UP_R_RD: begin
                w.rd    = RD_KIDS;
                w.tgt_t = UP_R_WR;
            end
            UP_R_WR: begin
                w.wr    = WR_KIDS;
                w.pop   = P_DEC;
                w.cond  = C_P_ONE;
                w.tgt_t = UP_IDLE;
                w.tgt_f = UP_R_RD;
            end
            // point update
            UP_U_LD: begin
                w.pop   = P_LOAD;
                w.cond  = C_UPD_BAD;
                w.tgt_t = UP_IDLE;
                w.tgt_f = UP_U_RD;
            end
            UP_U_RD: begin
                w.rd    = RD_P;
                w.tgt_t = UP_U_CHK;
            end
            UP_U_CHK: begin
                w.cond  = C_SAME;
                w.tgt_t = UP_IDLE;
                w.tgt_f = UP_U_WR;
            end
            UP_U_WR: begin
                w.wr    = WR_VAL;
                w.pop   = P_HALF;
                w.tgt_t = UP_U_KRD;
            end
            UP_U_KRD: begin
                w.rd    = RD_KIDS;
                w.tgt_t = UP_U_KWR;
            end
            UP_U_KWR: begin
                w.wr    = WR_KIDS;
                w.pop   = P_HALF;
                w.cond  = C_P_ONE;
                w.tgt_t = UP_IDLE;
                w.tgt_f = UP_U_KRD;
            end
            // range query
            UP_Q_LD: begin
                w.lrop  = LR_LOAD;
                w.accop = ACC_INIT;
                w.cond  = C_QRY_BAD;
                w.tgt_t = UP_Q_ERR;
                w.tgt_f = UP_Q_RD;
            end
            UP_Q_RD: begin
                w.rd    = RD_LR;
                w.cond  = C_LR_DONE;
                w.tgt_t = UP_Q_OUT;
                w.tgt_f = UP_Q_ACC;
            end
            UP_Q_ACC: begin
                w.accop = ACC_FOLD;
                w.lrop  = LR_STEP;
                w.tgt_t = UP_Q_RD;
            end
            UP_Q_OUT: begin
                w.outop = OUT_ACC;
            end
            UP_Q_ERR: begin
                w.outop = OUT_ERR;
            end
            default: begin
                w.dispatch = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/strmm_if.sv */
// ----------------------------------------------------------------------------
// strmm channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface strmm_in_if
    import strmm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] new_value;
    logic [IDX_W-1:0] range_low;
    logic [IDX_W-1:0] range_high;

    modport source (output valid, op, entry_index, new_value, range_low, range_high,
                    input ready);
    modport sink   (input valid, op, entry_index, new_value, range_low, range_high,
                    output ready);
endinterface

interface strmm_out_if
    import strmm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] reduced_value;
    logic             range_error;

    modport source (output valid, reduced_value, range_error, input ready);
    modport sink   (input valid, reduced_value, range_error, output ready);
endinterface

/* sv/segment_tree_range_min_max_core.sv */
// ----------------------------------------------------------------------------
// segment_tree_range_min_max_core
// range min/max reduction tree with monotone point updates, microcoded
// ----------------------------------------------------------------------------
// Holds DEPTH 16-bit entries in a binary reduction tree of 2*DEPTH nodes kept
// in one node memory with two registered read ports and one write port. A
// short microprogram walks the tree level by level, with a read step and then
// a combine/write step per level; a rejected or unchanged update returns to
// idle without walking the tree. One transaction is in flight at a time; its
// result sits in an output register so the next transaction is taken while
// the result waits. After reset and after every combine_mode write the tree
// is rebuilt by a pass (DEPTH leaf writes, then a read and a write step per
// inner node) during which no transaction is accepted; register writes are
// taken as ever.
// ----------------------------------------------------------------------------
module segment_tree_range_min_max_core
    import strmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    strmm_in_if.sink           i_in,
    strmm_out_if.source        o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // node address width and walk index width (query bound reaches 2*DEPTH)
    localparam int ENTRIES = 2 * DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int NW      = AW + 1;

    // sequencer
    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;

    // config
    logic r_mode;
    logic mode_wr;

    // captured transaction
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;

    // datapath
    logic [AW-1:0]    r_p;
    logic [NW-1:0]    r_l;
    logic [NW-1:0]    r_r;
    logic [NW-1:0]    dec_r;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] q_a;
    logic [VAL_W-1:0] q_b;
    logic [VAL_W-1:0] new_leaf;
    logic [VAL_W-1:0] kid_comb;
    logic [VAL_W-1:0] fold_l;
    logic [VAL_W-1:0] fold_lr;

    // memory control
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // conditions and handshakes
    logic cond_hit;
    logic in_fire;
    logic out_free;
    logic stall;

    // result register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_err;

    assign uw = f_ucode(r_pc);

    // ------------------------------------------------------------------
    // register port: a mode write reloads the tree
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign mode_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
    assign prdata  = (paddr[2] == REG_MODE) ? {{(PDATA_W-1){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MIN;
        end else if (mode_wr) begin
            r_mode <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign i_in.ready = (r_pc == UP_IDLE) && !mode_wr;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    // result steps wait for room in the output register
    assign stall      = (uw.outop != OUT_NONE) && !out_free;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx <= i_in.entry_index;
            r_val <= i_in.new_value;
            r_lo  <= i_in.range_low;
            r_hi  <= i_in.range_high;
        end
    end

    // ------------------------------------------------------------------
    // combine units
    // ------------------------------------------------------------------
    assign new_leaf = f_comb(r_mode, q_a, r_val);
    assign kid_comb = f_comb(r_mode, q_a, q_b);
    // the accumulator stands in for a node that the walk does not take
    assign fold_l   = f_comb(r_mode, r_acc, r_l[0] ? q_a : r_acc);
    assign fold_lr  = f_comb(r_mode, fold_l, r_r[0] ? q_b : r_acc);
    assign dec_r    = r_r - NW'(1);

    // ------------------------------------------------------------------
    // branch condition select
    // ------------------------------------------------------------------
    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_LEAF_LAST: cond_hit = (32'(r_p) == 32'(DEPTH - 1));
            C_P_ONE:     cond_hit = (r_p == AW'(1));
            C_UPD_BAD:   cond_hit = (32'(r_idx) >= 32'(DEPTH));
            C_QRY_BAD:   cond_hit = (r_lo > r_hi) || (32'(r_hi) >= 32'(DEPTH));
            C_SAME:      cond_hit = (new_leaf == q_a);
            C_LR_DONE:   cond_hit = (r_l >= r_r);
            default:     cond_hit = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // next step
    // ------------------------------------------------------------------
    always_comb begin
        n_pc = r_pc;
        if (mode_wr) begin
            n_pc = UP_R_INIT;
        end else if (uw.dispatch) begin
            if (in_fire) begin
                n_pc = (i_in.op == OP_QUERY) ? UP_Q_LD : UP_U_LD;
            end
        end else if (!stall) begin
            n_pc = cond_hit ? uw.tgt_t : uw.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UP_R_INIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // ------------------------------------------------------------------
    // memory port decode from the control word
    // ------------------------------------------------------------------
    always_comb begin
        rd_en = (uw.rd != RD_NONE);
        unique case (uw.rd)
            RD_KIDS: begin
                rd_addr_a = {r_p[AW-2:0], 1'b0};
                rd_addr_b = {r_p[AW-2:0], 1'b1};
            end
            RD_LR: begin
                rd_addr_a = r_l[AW-1:0];
                rd_addr_b = dec_r[AW-1:0];
            end
            default: begin
                rd_addr_a = r_p;
                rd_addr_b = r_p;
            end
        endcase
    end

    always_comb begin
        wr_en = (uw.wr != WR_NONE);
        unique case (uw.wr)
            WR_LEAF: begin
                wr_addr = AW'(32'(DEPTH) + 32'(r_p));
                wr_data = VAL_W'(r_p);
            end
            WR_VAL: begin
                wr_addr = r_p;
                wr_data = new_leaf;
            end
            default: begin
                wr_addr = r_p;
                wr_data = kid_comb;
            end
        endcase
    end

    strmm_node_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .DW      (VAL_W)
    ) u_node_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (q_a),
        .o_rd_data_b (q_b)
    );

    // ------------------------------------------------------------------
    // node pointer, walk bounds and accumulator
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (uw.pop)
            P_CLR:   r_p <= '0;
            P_INC:   r_p <= r_p + AW'(1);
            P_DEC:   r_p <= r_p - AW'(1);
            P_HALF:  r_p <= r_p >> 1;
            P_LOAD:  r_p <= AW'(32'(DEPTH) + 32'(r_idx));
            P_TOP:   r_p <= AW'(DEPTH - 1);
            default: r_p <= r_p;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.lrop)
            LR_LOAD: begin
                r_l <= NW'(32'(DEPTH) + 32'(r_lo));
                r_r <= NW'(32'(DEPTH) + 32'(r_hi) + 32'd1);
            end
            LR_STEP: begin
                // left bound steps past a right child, right bound back over a left one
                r_l <= (r_l + NW'(r_l[0])) >> 1;
                r_r <= (r_r - NW'(r_r[0])) >> 1;
            end
            default: begin
                r_l <= r_l;
                r_r <= r_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.accop)
            ACC_INIT: r_acc <= (r_mode == MODE_MAX) ? ACC_ID_MAX : ACC_ID_MIN;
            ACC_FOLD: r_acc <= fold_lr;
            default:  r_acc <= r_acc;
        endcase
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((uw.outop != OUT_NONE) && !stall) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((uw.outop != OUT_NONE) && !stall) begin
            r_out_value <= (uw.outop == OUT_ERR) ? '0 : r_acc;
            r_out_err   <= (uw.outop == OUT_ERR);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.reduced_value = r_out_value;
    assign o_out.range_error   = r_out_err;

endmodule

/* sv/strmm_node_ram.sv */
// ----------------------------------------------------------------------------
// strmm_node_ram
// tree node store: one write port, two read ports with registered data
// ----------------------------------------------------------------------------
module strmm_node_ram #(
    parameter int ENTRIES = 2048,
    parameter int AW      = 11,
    parameter int DW      = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* sv/strmm_checker.sv */
// ----------------------------------------------------------------------------
// strmm_checker
// port-level checks of the range min/max tree core, bound to the top level
// ----------------------------------------------------------------------------
module strmm_checker
    import strmm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VAL_W-1:0]   i_out_value,
    input logic               i_out_err,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    logic mode_wr;

    assign mode_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);

    // a waiting result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
                                        && $stable(i_out_err))
        else $error("result changed while stalled");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> i_out_value == '0)
        else $error("error result with nonzero value");

    // mode readback follows the last write
    a_mode_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_wr |=> (paddr[2] != REG_MODE) || (prdata[0] == $past(pwdata[0])))
        else $error("mode readback mismatch");

    // a mode write starts the rebuild, which blocks new transactions
    a_rebuild_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_wr |=> !i_in_ready)
        else $error("transaction accepted during rebuild");

endmodule

bind segment_tree_range_min_max_core strmm_checker u_strmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.reduced_value),
    .i_out_err   (o_out.range_error),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

/* dv/tb_segment_tree_range_min_max_core.sv */
// ----------------------------------------------------------------------------
// tb_segment_tree_range_min_max_core
// self-checking bench for the range min/max reduction tree core
// ----------------------------------------------------------------------------
// Feeds point updates and range queries through the request channel and
// checks every result against a shadow copy of the entries kept in the bench.
// The shadow is a flat array of leaves, so a query is answered by a plain
// scan of the range. The combine mode is written over the APB port between
// phases, with a read-back of the register each time. Both channel sides
// insert short random gaps, and the result side holds off once for a long
// stretch so that the core backs up and stalls its request side.
// ----------------------------------------------------------------------------
module tb_segment_tree_range_min_max_core;
    import strmm_pkg::*;

    localparam int N_ENTRIES     = DEPTH_DEF;
    // margin for the longest changing update or query to finish
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] new_value;
        logic [IDX_W-1:0] range_low;
        logic [IDX_W-1:0] range_high;
    } t_tree_request;

    typedef struct {
        logic [VAL_W-1:0] reduced_value;
        logic             range_error;
    } t_range_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    strmm_in_if  req_ch ();
    strmm_out_if res_ch ();

    segment_tree_range_min_max_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the core: leaf values and the combine mode
    logic [VAL_W-1:0] entry_shadow [N_ENTRIES];
    logic             shadow_mode;

    t_tree_request requests_waiting [$];
    t_range_answer answers_due [$];

    int   n_failures;
    int   n_accepted;
    logic gaps_off;
    logic hold_off;

    // ------------------------------------------------------------------------
    // clock and time-zero values of every core input
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_UPDATE;
        req_ch.entry_index  = '0;
        req_ch.new_value    = '0;
        req_ch.range_low    = '0;
        req_ch.range_high   = '0;
        res_ch.ready        = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] keep_one(input logic mode,
                                                  input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        if (mode == MODE_MAX) begin
            return (b > a) ? b : a;
        end
        return (b < a) ? b : a;
    endfunction

    // after reset and any mode write every entry is back to its own index
    function automatic void reload_entries();
        for (int k = 0; k < N_ENTRIES; k++) begin
            entry_shadow[k] = VAL_W'(k);
        end
    endfunction

    // apply one accepted transaction; a query queues the answer it must give
    function automatic void tree_apply(input t_tree_request rq);
        t_range_answer    ans;
        logic [VAL_W-1:0] acc;
        int               lo;
        int               hi;
        lo = int'(rq.range_low);
        hi = int'(rq.range_high);
        if (rq.op == OP_UPDATE) begin
            // monotone: an unchanged entry leaves the tree as it was anyway
            if (int'(rq.entry_index) < N_ENTRIES) begin
                entry_shadow[rq.entry_index] =
                    keep_one(shadow_mode, entry_shadow[rq.entry_index], rq.new_value);
            end
        end else begin
            if (lo > hi || hi >= N_ENTRIES) begin
                ans.reduced_value = '0;
                ans.range_error   = 1'b1;
            end else begin
                acc = entry_shadow[lo];
                for (int k = lo + 1; k <= hi; k++) begin
                    acc = keep_one(shadow_mode, acc, entry_shadow[k]);
                end
                ans.reduced_value = acc;
                ans.range_error   = 1'b0;
            end
            answers_due = {answers_due, ans};
        end
    endfunction

    // ------------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------------
    // unused fields carry random bits so every input bit toggles
    task automatic push_update(input int idx, input logic [VAL_W-1:0] val);
        t_tree_request rq;
        rq.op          = OP_UPDATE;
        rq.entry_index = IDX_W'(idx);
        rq.new_value   = val;
        rq.range_low   = IDX_W'($urandom);
        rq.range_high  = IDX_W'($urandom);
        requests_waiting = {requests_waiting, rq};
    endtask

    task automatic push_query(input int lo, input int hi);
        t_tree_request rq;
        rq.op          = OP_QUERY;
        rq.entry_index = IDX_W'($urandom);
        rq.new_value   = VAL_W'($urandom);
        rq.range_low   = IDX_W'(lo);
        rq.range_high  = IDX_W'(hi);
        requests_waiting = {requests_waiting, rq};
    endtask

    task automatic push_random_requests(input int count);
        int               pick;
        int               idx;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] val;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // updates: values near the index range change entries often
                case ($urandom_range(0, 9))
                    0:       val = '0;
                    1:       val = '1;
                    2, 3, 4, 5: val = VAL_W'($urandom_range(0, N_ENTRIES - 1));
                    default: val = VAL_W'($urandom);
                endcase
                if ($urandom_range(0, 19) == 0) begin
                    idx = ($urandom_range(0, 1) == 0) ? 0 : N_ENTRIES - 1;
                end else begin
                    idx = $urandom_range(0, N_ENTRIES - 1);
                end
                push_update(idx, val);
            end else if (pick < 52) begin
                // reversed range
                lo = $urandom_range(1, N_ENTRIES - 1);
                hi = $urandom_range(0, lo - 1);
                push_query(lo, hi);
            end else if (pick < 62) begin
                // point read
                lo = $urandom_range(0, N_ENTRIES - 1);
                push_query(lo, lo);
            end else if (pick < 75) begin
                lo = $urandom_range(0, N_ENTRIES - 1);
                hi = lo + $urandom_range(0, 15);
                if (hi > N_ENTRIES - 1) begin
                    hi = N_ENTRIES - 1;
                end
                push_query(lo, hi);
            end else if (pick < 83) begin
                // anchored at either end of the entries
                if ($urandom_range(0, 1) == 0) begin
                    push_query(0, $urandom_range(0, N_ENTRIES - 1));
                end else begin
                    push_query($urandom_range(0, N_ENTRIES - 1), N_ENTRIES - 1);
                end
            end else begin
                lo = $urandom_range(0, N_ENTRIES - 1);
                hi = $urandom_range(lo, N_ENTRIES - 1);
                push_query(lo, hi);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // APB access to the mode register
    // ------------------------------------------------------------------------
    task automatic mode_write(input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only bit 0 is kept, and the tree goes back to its reset contents
        shadow_mode = value[0];
        reload_entries();
    endtask

    task automatic mode_readback();
        logic [PDATA_W-1:0] seen;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_MODE, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        // read data sampled mid access cycle
        @(negedge i_clk);
        seen = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== PDATA_W'(shadow_mode)) begin
            $error("combine_mode read-back: expected %0d, actual 0x%08h", shadow_mode, seen);
            n_failures++;
        end
    endtask

    // wait for every answer, then let a trailing update finish its walk
    task automatic drain_core();
        while (requests_waiting.size() != 0 || answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // request driver: holds the front transaction until it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        t_tree_request taken;
        logic          busy;
        int            gap_left;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                taken = requests_waiting.pop_front();
                tree_apply(taken);
                n_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (requests_waiting.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (!gaps_off && $urandom_range(0, 4) == 0) begin
                    // this cycle is the first idle one of a gap
                    gap_left = $urandom_range(0, 2);
                    req_ch.valid <= 1'b0;
                end else begin
                    req_ch.valid       <= 1'b1;
                    req_ch.op          <= requests_waiting[0].op;
                    req_ch.entry_index <= requests_waiting[0].entry_index;
                    req_ch.new_value   <= requests_waiting[0].new_value;
                    req_ch.range_low   <= requests_waiting[0].range_low;
                    req_ch.range_high  <= requests_waiting[0].range_high;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and ready driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_range_answer want;
        int            stall_left;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result transaction with no query outstanding: value 0x%04h error %0d",
                           res_ch.reduced_value, res_ch.range_error);
                    n_failures++;
                end else begin
                    want = answers_due.pop_front();
                    if (res_ch.reduced_value !== want.reduced_value) begin
                        $error("reduced_value: expected 0x%04h, actual 0x%04h",
                               want.reduced_value, res_ch.reduced_value);
                        n_failures++;
                    end
                    if (res_ch.range_error !== want.range_error) begin
                        $error("range_error: expected %0d, actual %0d",
                               want.range_error, res_ch.range_error);
                        n_failures++;
                    end
                end
            end
            if (hold_off) begin
                res_ch.ready <= 1'b0;
            end else if (gaps_off) begin
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // long hold-off on the result side; the core fills its output register
    // and must then stall the request side while requests keep coming
    initial begin : result_hold
        hold_off = 1'b0;
        while (n_accepted < 150) @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // phases: min after reset, max, max rewritten, min with no gaps
    // ------------------------------------------------------------------------
    initial begin : stimulus_main
        n_failures  = 0;
        n_accepted  = 0;
        gaps_off    = 1'b0;
        shadow_mode = MODE_MIN;
        reload_entries();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // min mode from reset; requests wait out the rebuild pass
        @(negedge i_clk);
        push_query(0, N_ENTRIES - 1);
        push_query(N_ENTRIES - 1, N_ENTRIES - 1);
        push_query(0, 0);
        push_query(700, 300);
        push_query(N_ENTRIES - 1, 0);
        push_update(N_ENTRIES - 1, '1);       // unchanged, dropped
        push_update(N_ENTRIES - 1, '0);
        push_query(N_ENTRIES - 2, N_ENTRIES - 1);
        push_update(512, 5);
        push_update(512, 5);                  // same value again, dropped
        push_query(511, 513);
        push_query(513, N_ENTRIES - 2);
        push_random_requests(250);
        drain_core();

        // max mode, upper data bits must be ignored
        mode_write(($urandom() & ~32'h1) | 32'h1);
        mode_readback();
        @(negedge i_clk);
        push_query(0, N_ENTRIES - 1);
        push_update(0, '1);
        push_query(0, N_ENTRIES - 1);
        push_update(0, '0);                   // unchanged under max
        push_update(N_ENTRIES - 1, 1000);     // unchanged under max
        push_update(N_ENTRIES - 1, 1024);
        push_query(1000, N_ENTRIES - 1);
        push_query(1, 1);
        push_query(N_ENTRIES - 1, N_ENTRIES - 2);
        push_random_requests(300);
        drain_core();

        // same mode written again: updates so far must be wiped
        mode_write(($urandom() & ~32'h1) | 32'h1);
        mode_readback();
        @(negedge i_clk);
        push_query(0, N_ENTRIES - 1);
        push_query(0, 0);
        push_random_requests(250);
        drain_core();

        // back to min, no idling on either side to the end
        mode_write($urandom() & ~32'h1);
        mode_readback();
        gaps_off <= 1'b1;
        @(negedge i_clk);
        push_query(0, N_ENTRIES - 1);
        push_random_requests(470);
        drain_core();

        if (n_failures == 0) begin
            $display("segment_tree_range_min_max_core test passed");
        end else begin
            $display("segment_tree_range_min_max_core test failed");
        end
        $finish;
    end

    // several times the slowest legal run, rebuild passes included
    initial begin : watchdog
        #1000000;
        $display("segment_tree_range_min_max_core test failed");
        $finish;
    end

endmodule
